### rtl/core/tdpt_pkg.sv
// shared types and constants for the trial division primality tester
package tdpt_pkg;

    localparam int unsigned FIRST_CANDIDATE    = 5;
    localparam int unsigned CANDIDATE_STEP     = 6;
    localparam int unsigned CANDIDATE_GAP      = 2;
    localparam int unsigned SMALLEST_COMPOSITE = 4;
    localparam int unsigned SMALLEST_PRIME     = 2;
    localparam int unsigned SECOND_PRIME       = 3;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_stat;

    typedef struct packed {
        logic init;
        logic step;
    } t_bound_req;

endpackage

### rtl/core/tdpt_rem.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
module tdpt_rem #(
    parameter int VALUE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [VALUE_BITS-1:0]    i_dividend,
    input  logic [VALUE_BITS-1:0]    i_divisor,
    output tdpt_pkg::t_rem_stat      o_stat
);

    localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic                  r_busy;
    logic                  r_done;
    logic                  r_zero;
    logic [CW-1:0]         r_cnt;
    logic [VALUE_BITS-1:0] r_dvd;
    logic [VALUE_BITS-1:0] r_dvs;
    logic [VALUE_BITS-1:0] r_rem;

    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;
    logic [VALUE_BITS-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[VALUE_BITS-1]};
        diff  = trial - {1'b0, r_dvs};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = diff[VALUE_BITS-1:0];
        end else begin
            n_rem = trial[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(VALUE_BITS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[VALUE_BITS-2:0], 1'b0};
            r_rem  <= n_rem;
            r_cnt  <= r_cnt + CW'(1);
            r_zero <= (n_rem == '0);
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = r_zero;

endmodule

### rtl/core/tdpt_bound.sv
// candidate divisor pair and running square for the loop bound
module tdpt_bound #(
    parameter int VALUE_BITS = 32
) (
    input  logic                     i_clk,
    input  tdpt_pkg::t_bound_req     i_req,
    input  logic [VALUE_BITS-1:0]    i_value,
    output logic [VALUE_BITS-1:0]    o_cand,
    output logic [VALUE_BITS-1:0]    o_cand2,
    output logic                     o_over
);

    localparam int SW = VALUE_BITS + 2;
    localparam int F  = int'(tdpt_pkg::FIRST_CANDIDATE);
    localparam int S  = int'(tdpt_pkg::CANDIDATE_STEP);
    localparam int G  = int'(tdpt_pkg::CANDIDATE_GAP);

    logic [VALUE_BITS-1:0] r_cand;
    logic [VALUE_BITS-1:0] r_cand2;
    logic [SW-1:0]         r_sq;
    logic [SW-1:0]         r_inc;

    always_ff @(posedge i_clk) begin
        if (i_req.init) begin
            r_cand  <= VALUE_BITS'(F);
            r_cand2 <= VALUE_BITS'(F + G);
            r_sq    <= SW'(F * F);
            r_inc   <= SW'(2 * F * S + S * S);
        end else if (i_req.step) begin
            r_cand  <= r_cand + VALUE_BITS'(S);
            r_cand2 <= r_cand2 + VALUE_BITS'(S);
            r_sq    <= r_sq + r_inc;
            r_inc   <= r_inc + SW'(2 * S * S);
        end
    end

    assign o_cand  = r_cand;
    assign o_cand2 = r_cand2;
    assign o_over  = (r_sq > {2'b00, i_value});

endmodule

### rtl/core/trial_division_primality_test.sv
// trial division primality tester over 6k-1 / 6k+1 candidates
// values below 4 and even values are decided without division; others are divided by 3,
// then by each 6k-1 / 6k+1 candidate pair until the square of 6k-1 exceeds the value
// throughput: one request at a time, paced by the bit-serial remainder unit
// a finished result waits in its output register while the next request is taken
// synchronous active-low reset returns to idle with no result pending
module trial_division_primality_test #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_is_prime_flag
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_DIV3  = 7'b0000100,
        S_TEST  = 7'b0001000,
        S_DIVA  = 7'b0010000,
        S_DIVB  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    localparam logic [VALUE_BITS-1:0] TWO  =
        VALUE_BITS'(tdpt_pkg::SMALLEST_PRIME);
    localparam logic [VALUE_BITS-1:0] THREE =
        VALUE_BITS'(tdpt_pkg::SECOND_PRIME);
    localparam logic [VALUE_BITS-1:0] FOUR =
        VALUE_BITS'(tdpt_pkg::SMALLEST_COMPOSITE);

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [VALUE_BITS-1:0] r_divisor, n_divisor;
    logic                  r_go, n_go;
    logic                  r_flag, n_flag;
    logic                  r_out_valid;
    logic                  r_out_flag;
    logic                  load_out;

    tdpt_pkg::t_rem_stat   rem_stat;
    tdpt_pkg::t_bound_req  n_req;
    logic [VALUE_BITS-1:0] cand;
    logic [VALUE_BITS-1:0] cand2;
    logic                  over;

    tdpt_rem #(
        .VALUE_BITS(VALUE_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_dividend (r_value),
        .i_divisor  (r_divisor),
        .o_stat     (rem_stat)
    );

    tdpt_bound #(
        .VALUE_BITS(VALUE_BITS)
    ) u_bound (
        .i_clk   (i_clk),
        .i_req   (n_req),
        .i_value (r_value),
        .o_cand  (cand),
        .o_cand2 (cand2),
        .o_over  (over)
    );

    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state   = r_state;
        n_value   = r_value;
        n_divisor = r_divisor;
        n_go      = 1'b0;
        n_flag    = r_flag;
        n_req     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_value = i_value;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_value < TWO) begin
                    n_flag  = 1'b0;
                    n_state = S_DONE;
                end else if (r_value < FOUR) begin
                    n_flag  = 1'b1;
                    n_state = S_DONE;
                end else if (!r_value[0]) begin
                    n_flag  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_go      = 1'b1;
                    n_divisor = THREE;
                    n_state   = S_DIV3;
                end
            end
            S_DIV3: begin
                if (rem_stat.done) begin
                    if (rem_stat.zero) begin
                        n_flag  = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_req.init = 1'b1;
                        n_state    = S_TEST;
                    end
                end
            end
            S_TEST: begin
                if (over) begin
                    n_flag  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_go      = 1'b1;
                    n_divisor = cand;
                    n_state   = S_DIVA;
                end
            end
            S_DIVA: begin
                if (rem_stat.done) begin
                    if (rem_stat.zero) begin
                        n_flag  = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_go      = 1'b1;
                        n_divisor = cand2;
                        n_state   = S_DIVB;
                    end
                end
            end
            S_DIVB: begin
                if (rem_stat.done) begin
                    if (rem_stat.zero) begin
                        n_flag  = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_req.step = 1'b1;
                        n_state    = S_TEST;
                    end
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_divisor <= n_divisor;
        r_flag    <= n_flag;
        if (load_out) begin
            r_out_flag <= r_flag;
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_is_prime_flag = r_out_flag;

`ifndef SYNTH
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");

    a_go_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |-> (r_state == S_DIV3 || r_state == S_DIVA || r_state == S_DIVB))
        else $error("remainder start outside a divide state");

    a_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.done |-> (r_state == S_DIV3 || r_state == S_DIVA || r_state == S_DIVB))
        else $error("remainder finished with no divide pending");
`endif

endmodule

### verif/tdpt_result_checker.sv
// request/result checker with its own primality predictor for the trial division tester
`timescale 1ns / 1ps

module tdpt_result_checker #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_stall,
    input  logic [VALUE_BITS-1:0] i_req_value,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic                  i_res_is_prime_flag,
    output int                    o_mismatch_count,
    output int                    o_outstanding
);

    localparam longint unsigned LOWEST_PRIME    = 2;
    localparam longint unsigned NEXT_PRIME      = 3;
    localparam longint unsigned LOWEST_NONPRIME = 4;
    localparam longint unsigned START_DIVISOR   = 5;
    localparam longint unsigned DIVISOR_STRIDE  = 6;
    localparam longint unsigned PAIR_OFFSET     = 2;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  flag;
    } t_expected_verdict;

    t_expected_verdict pending_verdicts[$];
    t_expected_verdict head_verdict;
    t_expected_verdict new_verdict;
    int                mismatches = 0;

    // 6k-1 / 6k+1 trial division, bound kept as d <= n/d so it never overflows
    function automatic logic prime_verdict(input logic [VALUE_BITS-1:0] candidate);
        longint unsigned n;
        longint unsigned d;
        n = candidate;
        if (n < LOWEST_PRIME) return 1'b0;
        if (n < LOWEST_NONPRIME) return 1'b1;
        if ((n % LOWEST_PRIME) == 0 || (n % NEXT_PRIME) == 0) return 1'b0;
        for (d = START_DIVISOR; d <= n / d; d += DIVISOR_STRIDE) begin
            if ((n % d) == 0 || (n % (d + PAIR_OFFSET)) == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res_valid && !i_res_stall) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    head_verdict = pending_verdicts.pop_front();
                    if (i_res_is_prime_flag !== head_verdict.flag)
                        report_mismatch($sformatf("value %0d: is_prime_flag %b, expected %b",
                            head_verdict.value, i_res_is_prime_flag, head_verdict.flag));
                end
            end
            if (i_req_valid && !i_req_stall) begin
                new_verdict.value = i_req_value;
                new_verdict.flag  = prime_verdict(i_req_value);
                pending_verdicts.push_back(new_verdict);
            end
        end
        o_outstanding    <= pending_verdicts.size();
        o_mismatch_count <= mismatches;
    end

endmodule

### verif/tb_trial_division_primality_test.sv
// stimulus, reset, watchdog and verdict for the trial division primality tester
`timescale 1ns / 1ps

module tb_trial_division_primality_test;

    localparam int VALUE_BITS     = 32;
    localparam int RESET_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 800;
    localparam int RANDOM_ITEMS   = 70;
    localparam int QUIET_ITEMS    = 20;
    localparam int TAIL_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [VALUE_BITS-1:0] i_value;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_is_prime_flag;

    int mismatch_count;
    int outstanding;
    int idle_cycles = 0;
    bit idling_on = 1'b0;
    bit hold_off_req = 1'b0;

    logic [VALUE_BITS-1:0] directed_values [0:24] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9,
        32'd25, 32'd29, 32'd31, 32'd35, 32'd49, 32'd121, 32'd143, 32'd289,
        32'd323, 32'd529, 32'd4294967291, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
        32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAB
    };

    int unsigned small_factors [0:12] = '{5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

    always #6 i_clk = ~i_clk;

    trial_division_primality_test #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_prime_flag(o_is_prime_flag)
    );

    tdpt_result_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_stall        (o_stall),
        .i_req_value        (i_value),
        .i_res_valid        (o_valid),
        .i_res_stall        (i_stall),
        .i_res_is_prime_flag(o_is_prime_flag),
        .o_mismatch_count   (mismatch_count),
        .o_outstanding      (outstanding)
    );

    // mostly small values; wide ones always carry a small factor to keep the run short
    function automatic logic [VALUE_BITS-1:0] random_candidate();
        int unsigned p;
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 3) return $urandom_range(0, 40);
        if (sel < 12) return $urandom_range(0, 4095);
        if (sel < 14) return $urandom_range(4096, 1 << 20);
        if (sel < 16) return $urandom & ~32'd1;
        if (sel < 17) return 32'd3 * $urandom_range(1, 32'hFFFF_FFFF / 3);
        p = small_factors[$urandom_range(0, 12)];
        return p * $urandom_range(1, 32'hFFFF_FFFF / p);
    endfunction

    task automatic send_request(input logic [VALUE_BITS-1:0] v);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // receiver side
    initial begin
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL trial_division_primality_test");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idling_on = 1'b1;

        foreach (directed_values[k])
            send_request(directed_values[k]);

        // receiver holds off while requests keep coming, so the block backs up
        idling_on = 1'b0;
        hold_off_req = 1'b1;
        repeat (6)
            send_request($urandom_range(0, 200));
        drain_results();
        idling_on = 1'b1;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                idling_on = 1'b0;
            send_request(random_candidate());
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("PASS trial_division_primality_test");
        else
            $display("FAIL trial_division_primality_test");
        $finish;
    end

endmodule
